// ----- rtl/ersps_pkg.sv -----
// shared constants, payload types and codes of the sub-pixel row shifter
package ersps_pkg;

  // row store geometry and pixel format
  localparam int MaxWidth   = 4096;
  localparam int PixelBits  = 16;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int WidthBits  = ColBits + 1;
  localparam int LaneCount  = 3;

  // shift arithmetic: blend weights are scaled to 1024, the shift is q10,
  // so the fraction bits of the shift serve directly as the weight
  localparam int FracBits   = 10;
  localparam int WeightBits = 10;
  localparam int WeightOne  = 1 << WeightBits;

  // register and field widths
  localparam int StepBits   = 21;
  localparam int CountBits  = 11;
  localparam int ImageBits  = 10;
  localparam int DiffBits   = ImageBits + 1;
  localparam int ShiftBits  = StepBits + DiffBits;
  localparam int PosBits    = WidthBits + 2;
  localparam int CfgIdxBits = 2;

  typedef enum logic {
    ActLoad = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegShiftStep  = 2'd0,
    RegImageCount = 2'd1,
    RegRowWidth   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    action_e                action;
    logic [ImageBits-1:0]   image_index;
    logic [ColBits-1:0]     pixel_index;
    logic [PixelBits-1:0]   in_red;
    logic [PixelBits-1:0]   in_green;
    logic [PixelBits-1:0]   in_blue;
  } item_t;

  typedef struct packed {
    logic [PixelBits-1:0] out_red;
    logic [PixelBits-1:0] out_green;
    logic [PixelBits-1:0] out_blue;
    logic                 covered;
  } result_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0] index;
    logic [StepBits-1:0]   value;
  } cfg_t;

  // item after the input register
  typedef struct packed {
    action_e                            act;
    logic [ColBits-1:0]                 col;
    logic [LaneCount-1:0][PixelBits-1:0] pix;
    logic signed [DiffBits-1:0]         diff;
  } stage1_t;

  // row store access shared by all lanes
  typedef struct packed {
    logic               wr_en;
    logic [ColBits-1:0] wr_addr;
    logic               rd_en;
    logic [ColBits-1:0] rd_a;
    logic [ColBits-1:0] rd_b;
  } lane_req_t;

endpackage

// ----- rtl/ersps_if.sv -----
// valid/ready channels of the sub-pixel row shifter

interface ersps_item_if import ersps_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ersps_res_if import ersps_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ersps_cfg_if import ersps_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/epi_row_subpixel_shift_core.sv -----
// top level of the sub-pixel row shifter for epipolar plane images
//
// Takes one transaction per cycle while the result side keeps up: a load
// writes one pixel of the source row, a read returns column i of image k
// blended from two neighboring source pixels with linear weights of the
// q10 sub-pixel shift step*(k - count/2); every transaction gives exactly
// one result (zero for loads and uncovered columns). A transaction passes
// the input register, which loads at the accepting edge, then the shift
// multiply, the span check with the dual-port row store read, and the
// per-channel blend into the result register, each a registered stage.
// Three color lanes each hold their own row store and blend in
// parallel. When the result register is full and not taken, the whole
// pipeline holds and input ready drops. The row store has no reset and
// needs no clearing; a column must be loaded before it is read.

module epi_row_subpixel_shift_core import ersps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ersps_item_if.sink  item,
  ersps_res_if.source result,
  ersps_cfg_if.sink   cfg
);

  logic                                adv;
  logic signed [StepBits-1:0]          step_q;
  logic [ImageBits-1:0]                half_q;
  logic [WidthBits-1:0]                width_q;
  logic [WidthBits-1:0]                width_d;

  logic                                v1_q;
  stage1_t                             s1_q;
  stage1_t                             s1_d;

  lane_req_t                           lane_req;
  logic [LaneCount-1:0][PixelBits-1:0] wr_pix;
  logic [LaneCount-1:0][PixelBits-1:0] lane_pix;
  logic                                v3;
  logic                                cov3;
  logic [WeightBits-1:0]               f1;

  logic                                out_v_q;
  logic                                out_cov_q;

  // pipeline moves whenever the result register is free or being taken
  assign adv        = !out_v_q || result.ready;
  assign item.ready = adv;
  assign cfg.ready  = 1'b1;

  // configuration registers, row width kept already clamped
  always_comb begin
    width_d = cfg.data.value[WidthBits-1:0];
    if (width_d < WidthBits'(2)) width_d = WidthBits'(2);
    if (width_d > WidthBits'(MaxWidth)) width_d = WidthBits'(MaxWidth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      half_q  <= '0;
      width_q <= WidthBits'(MaxWidth);
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        RegShiftStep:  step_q  <= signed'(cfg.data.value);
        RegImageCount: half_q  <= cfg.data.value[1 +: ImageBits];
        RegRowWidth:   width_q <= width_d;
        default: ;
      endcase
    end
  end

  // input register
  always_comb begin
    s1_d.act  = item.data.action;
    s1_d.col  = item.data.pixel_index;
    s1_d.pix  = {item.data.in_blue, item.data.in_green, item.data.in_red};
    s1_d.diff = signed'({1'b0, item.data.image_index}) - signed'({1'b0, half_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= item.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
    end
  end

  ersps_shift u_shift (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .v1_i     (v1_q),
    .s1_i     (s1_q),
    .step_i   (step_q),
    .width_i  (width_q),
    .req_o    (lane_req),
    .wr_pix_o (wr_pix),
    .v3_o     (v3),
    .cov_o    (cov3),
    .f1_o     (f1)
  );

  // one lane per color channel
  for (genvar l = 0; l < LaneCount; l++) begin : g_lane
    ersps_lane u_lane (
      .clk_i     (clk_i),
      .adv_i     (adv),
      .req_i     (lane_req),
      .wr_data_i (wr_pix[l]),
      .f1_i      (f1),
      .cov_i     (cov3),
      .pix_o     (lane_pix[l])
    );
  end

  // result register: merges the lane results with the coverage flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      out_cov_q <= 1'b0;
    end else if (adv) begin
      out_v_q   <= v3;
      out_cov_q <= cov3;
    end
  end

  assign result.valid          = out_v_q;
  assign result.data.out_red   = lane_pix[0];
  assign result.data.out_green = lane_pix[1];
  assign result.data.out_blue  = lane_pix[2];
  assign result.data.covered   = out_cov_q;

  // an accepted transaction enters the pipeline
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.valid && item.ready |=> v1_q)
    else $error("accepted transaction missing from input stage");

  // a held stage keeps its transaction
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && v1_q |=> v1_q)
    else $error("transaction lost while the pipeline held");

  // coverage is only flagged for a live transaction
  a_cov_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cov3 |-> v3)
    else $error("coverage flagged on an empty stage");

  // uncovered results carry zero pixels
  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid && !result.data.covered |->
      (result.data.out_red == '0) && (result.data.out_green == '0) &&
      (result.data.out_blue == '0))
    else $error("uncovered result with nonzero pixel");

endmodule

// ----- rtl/ersps_ram.sv -----
// generic ram: one write port, two registered read ports

module ersps_ram #(
  parameter int Depth = 4096,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- rtl/ersps_shift.sv -----
// shift multiply and span/address stage, drives the row store of every lane

module ersps_shift import ersps_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                v1_i,
  input  stage1_t                             s1_i,
  input  logic signed [StepBits-1:0]          step_i,
  input  logic [WidthBits-1:0]                width_i,
  output lane_req_t                           req_o,
  output logic [LaneCount-1:0][PixelBits-1:0] wr_pix_o,
  output logic                                v3_o,
  output logic                                cov_o,
  output logic [WeightBits-1:0]               f1_o
);

  logic                                v2_q;
  logic signed [ShiftBits-1:0]         d_q;
  logic signed [ShiftBits-1:0]         d_d;
  action_e                             act2_q;
  logic [ColBits-1:0]                  col2_q;
  logic [LaneCount-1:0][PixelBits-1:0] pix2_q;

  logic                                v3_q;
  logic                                cov_q;
  logic [WeightBits-1:0]               f1_q;

  logic [ShiftBits-1:0]                mag;
  logic                                in_range;
  logic signed [PosBits-1:0]           off;
  logic signed [PosBits-1:0]           wv;
  logic signed [PosBits-1:0]           col_s;
  logic signed [PosBits-1:0]           lo;
  logic signed [PosBits-1:0]           hi;
  logic signed [PosBits-1:0]           ca;
  logic signed [PosBits-1:0]           cb;
  logic signed [PosBits-1:0]           ca_c;
  logic signed [PosBits-1:0]           cb_c;
  logic                                cov_d;

  function automatic logic signed [PosBits-1:0] clamp_pos(
    input logic signed [PosBits-1:0] v,
    input logic signed [PosBits-1:0] lo_v,
    input logic signed [PosBits-1:0] hi_v
  );
    logic signed [PosBits-1:0] r;
    r = v;
    if (v < lo_v) r = lo_v;
    if (v > hi_v) r = hi_v;
    return r;
  endfunction

  // shift for this image: step times distance from the center image
  assign d_d = ShiftBits'(step_i) * ShiftBits'(s1_i.diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q    <= d_d;
      act2_q <= s1_i.act;
      col2_q <= s1_i.col;
      pix2_q <= s1_i.pix;
    end
  end

  // span check and neighbor columns; off is only meaningful when in range
  always_comb begin
    mag      = d_q[ShiftBits-1] ? ShiftBits'(-d_q) : ShiftBits'(d_q);
    in_range = mag < {{(ShiftBits-WidthBits-FracBits){1'b0}}, width_i, {FracBits{1'b0}}};
    off      = signed'(d_q[FracBits +: PosBits]);
    wv       = signed'({2'b00, width_i});
    col_s    = signed'({{(PosBits-ColBits){1'b0}}, col2_q});
    lo       = clamp_pos(off, PosBits'(1), wv - PosBits'(1));
    hi       = clamp_pos(wv + off, PosBits'(1), wv - PosBits'(1));
    ca       = col_s - off;
    cb       = ca + PosBits'(1);
    ca_c     = clamp_pos(ca, '0, wv - PosBits'(1));
    cb_c     = clamp_pos(cb, '0, wv - PosBits'(1));
    cov_d    = v2_q && (act2_q == ActRead) && in_range && (col_s >= lo) && (col_s < hi);
  end

  // row store access: loads write in the same stage where reads happen,
  // so the order of transactions is kept
  always_comb begin
    req_o.wr_en   = adv_i && v2_q && (act2_q == ActLoad);
    req_o.wr_addr = col2_q;
    req_o.rd_en   = adv_i;
    req_o.rd_a    = ca_c[ColBits-1:0];
    req_o.rd_b    = cb_c[ColBits-1:0];
  end

  assign wr_pix_o = pix2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q  <= 1'b0;
      cov_q <= 1'b0;
    end else if (adv_i) begin
      v3_q  <= v2_q;
      cov_q <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f1_q <= d_q[WeightBits-1:0];
    end
  end

  assign v3_o  = v3_q;
  assign cov_o = cov_q;
  assign f1_o  = f1_q;

endmodule

// ----- rtl/ersps_lane.sv -----
// one color lane: row store of the channel and the two-tap blend

module ersps_lane import ersps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  lane_req_t             req_i,
  input  logic [PixelBits-1:0]  wr_data_i,
  input  logic [WeightBits-1:0] f1_i,
  input  logic                  cov_i,
  output logic [PixelBits-1:0]  pix_o
);

  localparam int SumBits = PixelBits + WeightBits + 1;

  logic [PixelBits-1:0]  rd_a;
  logic [PixelBits-1:0]  rd_b;
  logic [WeightBits:0]   f0;
  logic [SumBits-1:0]    sum;
  logic [PixelBits-1:0]  pix_q;

  ersps_ram #(
    .Depth (MaxWidth),
    .Width (PixelBits)
  ) u_row (
    .clk_i     (clk_i),
    .we_i      (req_i.wr_en),
    .waddr_i   (req_i.wr_addr),
    .wdata_i   (wr_data_i),
    .re_i      (req_i.rd_en),
    .raddr_a_i (req_i.rd_a),
    .raddr_b_i (req_i.rd_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // weighted sum of the two neighbors, weights add up to one
  always_comb begin
    f0  = (WeightBits+1)'(WeightOne) - (WeightBits+1)'(f1_i);
    sum = SumBits'(f1_i) * SumBits'(rd_a) + SumBits'(f0) * SumBits'(rd_b);
  end

  // lane result register, zero outside the span and for loads
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_q <= cov_i ? sum[WeightBits +: PixelBits] : '0;
    end
  end

  assign pix_o = pix_q;

endmodule
